>>> rtl/selective_repeat_receiver_defines.svh
// Assertion macros shared by the receiver RTL.
// Each macro expects clk and rst_n in scope.
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SRR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/srr_pkg.sv
`timescale 1ns / 1ps

package srr_pkg;

    // Sequence space and field widths
    localparam int SEQ_W     = 4;
    localparam int SEQ_SPACE = 16;
    localparam int CFG_W     = 4;
    localparam int ACK_W     = 5;
    localparam int LEN_W     = 8;
    localparam int TAG_W     = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_W-1:0] WIN_MIN     = 4'd1;
    localparam logic [CFG_W-1:0] WIN_MAX     = 4'd8;
    localparam logic [CFG_W-1:0] WIN_RESET   = 4'd4;
    localparam logic [LEN_W-1:0] PAYLOAD_MAX = 8'd128;
    localparam logic [ACK_W-1:0] NO_ACK      = 5'd16;

    // Result kinds
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK1,
        S_CHECK,
        S_DELIV,
        S_FINAL
    } srr_state_t;

    // One stored packet
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } srr_slot_t;

    // One result transaction
    typedef struct packed {
        logic             kind;
        logic [ACK_W-1:0] ack;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
        logic             last;
    } srr_result_t;

endpackage

>>> rtl/srr_out_stage.sv
`timescale 1ns / 1ps

// Single-entry output register between the sequencer and the master stream
module srr_out_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  srr_pkg::srr_result_t                result,
    output logic                                free,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // ack_number[4:0], data_len[12:5], data_tag[44:13], zero fill
    output logic [srr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // result_kind[0]
    output logic [0:0]                          m_axis_tuser,
    output logic                                m_axis_tlast
);
    import srr_pkg::*;

    logic        valid_reg;
    srr_result_t data_reg;

    // Slot can take a new result when empty or draining this cycle
    assign free = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= push;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (free && push)
        begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - ACK_W - LEN_W - TAG_W){1'b0}},
                            data_reg.tag, data_reg.len, data_reg.ack};
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tlast  = data_reg.last;

endmodule

>>> rtl/selective_repeat_receiver.sv
`timescale 1ns / 1ps
// Channel      Dir  Signals                               Contents
// s_axis       in   tvalid/tready/tdata[47:0]/tuser[0]    received packet header
// m_axis       out  tvalid/tready/tdata[47:0]/tuser[0]/   acknowledgements and
//                   tlast                                 delivered packets
// cfg          in   cfg_wr_en/cfg_wr_data[3:0]            window_size register
//
// Flow: a bad checksum is dropped; a good packet outside the window gets only
// the final ack; one in the window is stored and acked, each in-order slot is
// delivered (a registered slot memory read, then an emit), then the final ack.
// Reset: flags and expected number clear, last ack and window take their reset
// values at once; slot memory has no reset, read only after a slot's flag is set.
// Stalls: a full output register holds the sequencer; input is taken in idle.
`include "selective_repeat_receiver_defines.svh"

module selective_repeat_receiver (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [srr_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // seq_num[3:0], payload_len[11:4], payload_tag[43:12], zero fill
    input  logic [srr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // check_ok[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // ack_number[4:0], data_len[12:5], data_tag[44:13], zero fill
    output logic [srr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // result_kind[0]
    output logic [0:0]                          m_axis_tuser,
    output logic                                m_axis_tlast
);
    import srr_pkg::*;

    srr_state_t           state_reg, state_next;
    logic [CFG_W-1:0]     window_reg;
    logic [SEQ_W-1:0]     expected_reg;
    logic [ACK_W-1:0]     last_ack_reg;
    logic [SEQ_SPACE-1:0] flags_reg;
    srr_slot_t            slot_mem [SEQ_SPACE];
    srr_slot_t            rd_data_reg;

    logic                 accept;
    logic [SEQ_W-1:0]     in_seq;
    logic [LEN_W-1:0]     in_len;
    logic [TAG_W-1:0]     in_tag;
    logic                 in_ok;
    logic [CFG_W-1:0]     win_eff;
    logic [SEQ_W-1:0]     seq_dist;
    logic                 in_win;
    logic [LEN_W-1:0]     len_sat;
    logic                 mem_we;
    logic                 mem_re;
    logic                 push;
    logic                 deliv;
    logic                 out_free;
    srr_result_t          result;

    // Input unpacking
    assign accept = s_axis_tvalid && s_axis_tready;
    assign in_seq = s_axis_tdata[SEQ_W-1:0];
    assign in_len = s_axis_tdata[SEQ_W+LEN_W-1:SEQ_W];
    assign in_tag = s_axis_tdata[SEQ_W+LEN_W+TAG_W-1:SEQ_W+LEN_W];
    assign in_ok  = s_axis_tuser[0];

    // Window test modulo the sequence space, window size clamped to WIN_MIN..WIN_MAX
    always_comb
    begin
        if (window_reg < WIN_MIN)
        begin
            win_eff = WIN_MIN;
        end
        else if (window_reg > WIN_MAX)
        begin
            win_eff = WIN_MAX;
        end
        else
        begin
            win_eff = window_reg;
        end
    end

    assign seq_dist = in_seq - expected_reg;
    assign in_win   = (seq_dist < win_eff);
    assign len_sat  = (in_len > PAYLOAD_MAX) ? PAYLOAD_MAX : in_len;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_ok)
                begin
                    state_next = in_win ? S_ACK1 : S_FINAL;
                end
            end
            S_ACK1:
            begin
                if (out_free)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = flags_reg[expected_reg] ? S_DELIV : S_FINAL;
            end
            S_DELIV:
            begin
                if (out_free)
                begin
                    state_next = S_CHECK;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        push          = 1'b0;
        result.kind   = KIND_ACK;
        result.ack    = last_ack_reg;
        result.len    = '0;
        result.tag    = '0;
        result.last   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                mem_we        = accept && in_ok && in_win;
            end
            S_ACK1:
            begin
                push = out_free;
            end
            S_CHECK:
            begin
                mem_re = flags_reg[expected_reg];
            end
            S_DELIV:
            begin
                push        = out_free;
                result.kind = KIND_DATA;
                result.ack  = '0;
                result.len  = rd_data_reg.len;
                result.tag  = rd_data_reg.tag;
            end
            S_FINAL:
            begin
                push        = out_free;
                result.last = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // A delivery transaction leaves the sequencer
    assign deliv = push && (result.kind == KIND_DATA);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            window_reg   <= WIN_RESET;
            expected_reg <= '0;
            last_ack_reg <= NO_ACK;
            flags_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
            if (mem_we)
            begin
                flags_reg[in_seq] <= 1'b1;
                last_ack_reg      <= {{(ACK_W - SEQ_W){1'b0}}, in_seq};
            end
            if (deliv)
            begin
                flags_reg[expected_reg] <= 1'b0;
                expected_reg            <= expected_reg + 1'b1;
            end
        end
    end

    // Slot memory: write on store, registered read of the expected slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[in_seq] <= '{len: len_sat, tag: in_tag};
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[expected_reg];
        end
    end

    srr_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .result        (result),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Checks
    `SRR_ASSERT_SAME(a_deliv_flag, deliv, flags_reg[expected_reg], "delivery from an empty slot")
    `SRR_ASSERT_NEXT(a_last_idle, push && result.last, state_reg == S_IDLE,
        "sequencer not idle after final result")
    `SRR_ASSERT_NEXT(a_exp_stable, !deliv, $stable(expected_reg),
        "expected number moved without a delivery")

endmodule
